### hdl/sha_civ_pkg.sv
// ----------------------------------------------------------------------------
// sha_civ_pkg
// Shared types, constants and SHA-256 round functions for the custom-IV hasher.
// ----------------------------------------------------------------------------
package sha_civ_pkg;

    localparam int NUM_HASH_WORDS = 8;
    localparam int HASH_IDX_W     = 3;
    localparam int BLOCK_WORDS    = 16;
    localparam int TOTAL_W        = 29;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [NUM_HASH_WORDS-1:0][31:0] hash_t;

    // Standard SHA-256 initial hash, H0 in the lowest slot
    localparam hash_t RESET_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // One queued item, as classified by the front end
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } cmd_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ch(input logic [31:0] x, input logic [31:0] y,
                                       input logic [31:0] z);
        return (x & y) ^ (~x & z);
    endfunction

    function automatic logic [31:0] maj(input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] z);
        return (x & y) ^ (x & z) ^ (y & z);
    endfunction

    // Keep bytes ahead of the pad position, drop in the pad byte, zero the rest
    function automatic logic [31:0] pad_word(input logic [31:0] w, input logic [1:0] pb);
        logic [31:0] keep;
        unique case (pb)
            2'd0: keep = 32'h0000_0000;
            2'd1: keep = 32'hff00_0000;
            2'd2: keep = 32'hffff_0000;
            2'd3: keep = 32'hffff_ff00;
            default: keep = 32'h0000_0000;
        endcase
        return (w & keep) | ({24'd0, PAD_BYTE} << {~pb, 3'b000});
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] j);
        logic [31:0] k;
        unique case (j)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0000_0000;
        endcase
        return k;
    endfunction

endpackage

### hdl/sha_civ_front.sv
// ----------------------------------------------------------------------------
// sha_civ_front
// Input side: accepts message words, classifies them and queues them for the
// compression engine.
// ----------------------------------------------------------------------------
module sha_civ_front
    import sha_civ_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // message_byte
    input  logic       s_axis_tuser,   // has_byte
    input  logic       s_axis_tlast,   // end_of_message
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_pop
);

    localparam int AW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    cmd_t          queue_reg [QDEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push;
    logic          pop;
    cmd_t          incoming;

    assign s_axis_tready = (count_reg != CW'(QDEPTH));
    assign cmd_valid     = (count_reg != '0);
    assign cmd           = queue_reg[rd_ptr_reg];

    assign push = s_axis_tvalid & s_axis_tready;
    assign pop  = cmd_pop & cmd_valid;

    // Drop the data byte of a word that carries none
    always_comb
    begin
        incoming.data = s_axis_tuser ? s_axis_tdata : 8'd0;
        incoming.has  = s_axis_tuser;
        incoming.last = s_axis_tlast;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

### hdl/sha_civ_back.sv
// ----------------------------------------------------------------------------
// sha_civ_back
// Compression engine: assembles blocks, pads, runs one SHA-256 round per
// cycle and streams out the digest words.
// ----------------------------------------------------------------------------
module sha_civ_back
    import sha_civ_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  hash_t       iv,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // digest_word
    output logic [2:0]  m_axis_tuser,  // word_index
    output logic        m_axis_tlast   // last_word
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_FOLD  = 5'b00100,
        ST_PAD   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic                 in_msg_reg, in_msg_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [5:0]           round_reg, round_next;
    logic [HASH_IDX_W-1:0] idx_reg, idx_next;
    logic                 pad_pend_reg, pad_pend_next;
    logic                 second_reg, second_next;
    logic                 final_reg, final_next;

    // Block buffer doubles as the message schedule window during rounds
    logic [31:0] blk_reg  [BLOCK_WORDS];
    logic [31:0] blk_next [BLOCK_WORDS];
    logic [31:0] work_reg  [NUM_HASH_WORDS];
    logic [31:0] work_next [NUM_HASH_WORDS];
    hash_t       chain_reg, chain_next;

    hash_t              chain_in;
    hash_t              chain_sum;
    logic [TOTAL_W-1:0] total_base;
    logic [5:0]         pos;
    logic [31:0]        len_word;
    logic [31:0]        w_new;
    logic [31:0]        t1;
    logic [31:0]        t2;

    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata  = chain_reg[idx_reg];
    assign m_axis_tuser  = idx_reg;
    assign m_axis_tlast  = (idx_reg == HASH_IDX_W'(NUM_HASH_WORDS - 1));

    assign pos      = total_reg[5:0];
    assign len_word = {total_reg, 3'b000};

    always_comb
    begin
        chain_in   = in_msg_reg ? chain_reg : iv;
        total_base = in_msg_reg ? total_reg : '0;
        for (int i = 0; i < NUM_HASH_WORDS; i++)
        begin
            chain_sum[i] = chain_reg[i] + work_reg[i];
        end
        w_new = ssig1(blk_reg[14]) + blk_reg[9] + ssig0(blk_reg[1]) + blk_reg[0];
        t1 = work_reg[7] + bsig1(work_reg[4]) + ch(work_reg[4], work_reg[5], work_reg[6])
           + round_k(round_reg) + blk_reg[0];
        t2 = bsig0(work_reg[0]) + maj(work_reg[0], work_reg[1], work_reg[2]);
    end

    always_comb
    begin
        state_next    = state_reg;
        in_msg_next   = in_msg_reg;
        total_next    = total_reg;
        round_next    = round_reg;
        idx_next      = idx_reg;
        pad_pend_next = pad_pend_reg;
        second_next   = second_reg;
        final_next    = final_reg;
        chain_next    = chain_reg;
        blk_next      = blk_reg;
        work_next     = work_reg;
        cmd_pop       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    in_msg_next = 1'b1;
                    chain_next  = chain_in;
                    total_next  = total_base;
                    if (cmd.has)
                    begin
                        for (int w = 0; w < BLOCK_WORDS; w++)
                        begin
                            if (total_base[5:2] == 4'(w))
                            begin
                                blk_next[w][{~total_base[1:0], 3'b000} +: 8] = cmd.data;
                            end
                        end
                        total_next = total_base + 1'b1;
                    end
                    if (cmd.has && (total_base[5:0] == 6'd63))
                    begin
                        // Block full: compress, pad afterwards if this was the end
                        for (int i = 0; i < NUM_HASH_WORDS; i++)
                        begin
                            work_next[i] = chain_in[i];
                        end
                        round_next    = '0;
                        pad_pend_next = cmd.last;
                        state_next    = ST_ROUND;
                    end
                    else if (cmd.last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_ROUND:
            begin
                for (int i = 0; i < BLOCK_WORDS - 1; i++)
                begin
                    blk_next[i] = blk_reg[i + 1];
                end
                blk_next[BLOCK_WORDS - 1] = w_new;
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                round_next   = round_reg + 1'b1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_FOLD;
                end
            end

            ST_FOLD:
            begin
                chain_next = chain_sum;
                priority if (final_reg)
                begin
                    final_next = 1'b0;
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
                else if (second_reg)
                begin
                    // Length spilled over: one more block of zeros and the length
                    second_next = 1'b0;
                    final_next  = 1'b1;
                    for (int w = 0; w < BLOCK_WORDS; w++)
                    begin
                        blk_next[w] = 32'd0;
                    end
                    blk_next[BLOCK_WORDS - 1] = len_word;
                    for (int i = 0; i < NUM_HASH_WORDS; i++)
                    begin
                        work_next[i] = chain_sum[i];
                    end
                    round_next = '0;
                    state_next = ST_ROUND;
                end
                else if (pad_pend_reg)
                begin
                    pad_pend_next = 1'b0;
                    state_next    = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_PAD:
            begin
                for (int w = 0; w < BLOCK_WORDS; w++)
                begin
                    if (4'(w) == pos[5:2])
                    begin
                        blk_next[w] = pad_word(blk_reg[w], pos[1:0]);
                    end
                    else if (4'(w) > pos[5:2])
                    begin
                        blk_next[w] = 32'd0;
                    end
                end
                if (pos > 6'd55)
                begin
                    second_next = 1'b1;
                end
                else
                begin
                    blk_next[BLOCK_WORDS - 2] = 32'd0;
                    blk_next[BLOCK_WORDS - 1] = len_word;
                    final_next = 1'b1;
                end
                for (int i = 0; i < NUM_HASH_WORDS; i++)
                begin
                    work_next[i] = chain_reg[i];
                end
                round_next = '0;
                state_next = ST_ROUND;
            end

            ST_EMIT:
            begin
                if (m_axis_tready)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == HASH_IDX_W'(NUM_HASH_WORDS - 1))
                    begin
                        in_msg_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_msg_reg   <= 1'b0;
            total_reg    <= '0;
            round_reg    <= '0;
            idx_reg      <= '0;
            pad_pend_reg <= 1'b0;
            second_reg   <= 1'b0;
            final_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_msg_reg   <= in_msg_next;
            total_reg    <= total_next;
            round_reg    <= round_next;
            idx_reg      <= idx_next;
            pad_pend_reg <= pad_pend_next;
            second_reg   <= second_next;
            final_reg    <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chain_reg <= chain_next;
        blk_reg   <= blk_next;
        work_reg  <= work_next;
    end

endmodule

### hdl/sha256_custom_iv_hasher.sv
// ----------------------------------------------------------------------------
// sha256_custom_iv_hasher
// SHA-256 over a byte stream with a configurable initial hash value.
// ----------------------------------------------------------------------------
// Throughput: one byte word per cycle into the engine while it is idle; a full
//   64-byte block then holds off further words while its rounds and fold run.
// After the last word: dequeue, compression of any block it fills, a pad step,
//   rounds and a fold per final block (one or two), then 8 digest words, one per cycle when taken.
// Reset: initial hash returns to the standard values, queue and engine empty.
// ----------------------------------------------------------------------------
module sha256_custom_iv_hasher
    import sha_civ_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [HASH_IDX_W-1:0] cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // message_byte
    input  logic                  s_axis_tuser,   // has_byte
    input  logic                  s_axis_tlast,   // end_of_message
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // digest_word
    output logic [2:0]            m_axis_tuser,   // word_index
    output logic                  m_axis_tlast    // last_word
);

    hash_t iv_reg;
    hash_t iv_next;
    logic  cmd_valid;
    cmd_t  cmd;
    logic  cmd_pop;

    always_comb
    begin
        iv_next = iv_reg;
        if (cfg_we)
        begin
            iv_next[cfg_index] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= RESET_IV;
        end
        else
        begin
            iv_reg <= iv_next;
        end
    end

    sha_civ_front #(
        .QDEPTH(QDEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    sha_civ_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .iv           (iv_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

endmodule
